// File: rtl/core/rgs_pkg.sv
// Shared constants, types and the control store of the recursive Gaussian smoother.
`default_nettype none
package rgs_pkg;

	localparam int BUFFER_DEPTH = 1024;
	localparam int MAX_PASSES   = 16;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int LEN_W        = 11;
	localparam int PASS_W       = 5;
	localparam int COEF_W       = 16;
	localparam int EDGE_W       = 28;
	localparam int GAIN_W       = 32;
	localparam int SAMPLE_W     = 32;
	localparam int STORE_W      = 56;
	localparam int FRAC_W       = 16;
	localparam int HALF_W       = STORE_W / 2;
	localparam int PART_W       = HALF_W + GAIN_W;
	localparam int PROD_W       = STORE_W + GAIN_W;
	localparam int FUNC_W       = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int UPC_W        = 6;

	localparam logic [STORE_W-1:0] STORE_MAX = {STORE_W{1'b1}};

	// Input item codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PASS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FINAL = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_RD_DATA,
		ST_RUN_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_READ,
		OP_MLO,
		OP_MHI,
		OP_SUM,
		OP_RND,
		OP_WB
	} dp_op_t;

	typedef enum logic {
		A_MEM,
		A_CARRY
	} a_sel_t;

	typedef enum logic [1:0] {
		B_EDGE,
		B_NU,
		B_FINAL
	} b_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_LAST,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		PASS_HOLD,
		PASS_CLEAR,
		PASS_INC
	} pass_op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_LEN_ZERO,
		C_NO_PASS,
		C_SINGLE,
		C_NOT_LAST,
		C_NOT_FIRST,
		C_PASS_MORE
	} cond_t;

	typedef struct packed {
		dp_op_t             op;
		a_sel_t             a_sel;
		b_sel_t             b_sel;
		logic               sh32;
		logic               add_mem;
		idx_op_t            idx_op;
		pass_op_t           pass_op;
		cond_t              cond;
		logic [UPC_W-1:0]   target;
		logic               done;
	} ucode_t;

	typedef struct packed {
		dp_op_t             op;
		a_sel_t             a_sel;
		b_sel_t             b_sel;
		logic               sh32;
		logic               add_mem;
		logic [ADDR_W-1:0]  addr;
	} dp_ctl_t;

	// Program labels
	localparam logic [UPC_W-1:0] L_NONE       = 6'd0;
	localparam logic [UPC_W-1:0] L_PASS_TOP   = 6'd2;
	localparam logic [UPC_W-1:0] L_FWD_TOP    = 6'd9;
	localparam logic [UPC_W-1:0] L_BACK_SCALE = 6'd15;
	localparam logic [UPC_W-1:0] L_BWD_TOP    = 6'd22;
	localparam logic [UPC_W-1:0] L_PASS_END   = 6'd28;
	localparam logic [UPC_W-1:0] L_FINAL_TOP  = 6'd29;
	localparam logic [UPC_W-1:0] L_FINAL_LOOP = 6'd30;
	localparam logic [UPC_W-1:0] L_DONE       = 6'd36;

	function automatic ucode_t uw(input dp_op_t op, input a_sel_t a, input b_sel_t b,
			input logic sh32, input logic add_mem, input idx_op_t io, input pass_op_t po,
			input cond_t c, input logic [UPC_W-1:0] tgt, input logic done);
		ucode_t w;
		w.op      = op;
		w.a_sel   = a;
		w.b_sel   = b;
		w.sh32    = sh32;
		w.add_mem = add_mem;
		w.idx_op  = io;
		w.pass_op = po;
		w.cond    = c;
		w.target  = tgt;
		w.done    = done;
		return w;
	endfunction

	// Each element update: read, two partial products, sum, round, write back.
	function automatic ucode_t ucode_word(input logic [UPC_W-1:0] upc);
		ucode_t w;
		case (upc)
			6'd0:  w = uw(OP_NOP,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_ZERO, PASS_CLEAR,
				C_LEN_ZERO, L_DONE, 1'b0);
			6'd1:  w = uw(OP_NOP,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NO_PASS, L_FINAL_TOP, 1'b0);
			// scale first entry
			6'd2:  w = uw(OP_NOP,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_ZERO, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd3:  w = uw(OP_READ, A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd4:  w = uw(OP_MLO,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd5:  w = uw(OP_MHI,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd6:  w = uw(OP_SUM,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd7:  w = uw(OP_RND,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd8:  w = uw(OP_WB,   A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_INC,  PASS_HOLD,
				C_SINGLE, L_BACK_SCALE, 1'b0);
			// causal recursion
			6'd9:  w = uw(OP_READ, A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd10: w = uw(OP_MLO,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd11: w = uw(OP_MHI,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd12: w = uw(OP_SUM,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd13: w = uw(OP_RND,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd14: w = uw(OP_WB,   A_CARRY, B_NU,    1'b0, 1'b1, IDX_INC,  PASS_HOLD,
				C_NOT_LAST, L_FWD_TOP, 1'b0);
			// scale last entry
			6'd15: w = uw(OP_NOP,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_LAST, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd16: w = uw(OP_READ, A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd17: w = uw(OP_MLO,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd18: w = uw(OP_MHI,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd19: w = uw(OP_SUM,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd20: w = uw(OP_RND,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd21: w = uw(OP_WB,   A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_DEC,  PASS_HOLD,
				C_SINGLE, L_PASS_END, 1'b0);
			// anti-causal recursion
			6'd22: w = uw(OP_READ, A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd23: w = uw(OP_MLO,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd24: w = uw(OP_MHI,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd25: w = uw(OP_SUM,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd26: w = uw(OP_RND,  A_CARRY, B_NU,    1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd27: w = uw(OP_WB,   A_CARRY, B_NU,    1'b0, 1'b1, IDX_DEC,  PASS_HOLD,
				C_NOT_FIRST, L_BWD_TOP, 1'b0);
			6'd28: w = uw(OP_NOP,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_INC,
				C_PASS_MORE, L_PASS_TOP, 1'b0);
			// post scale
			6'd29: w = uw(OP_NOP,  A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_ZERO, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd30: w = uw(OP_READ, A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd31: w = uw(OP_MLO,  A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd32: w = uw(OP_MHI,  A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd33: w = uw(OP_SUM,  A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd34: w = uw(OP_RND,  A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b0);
			6'd35: w = uw(OP_WB,   A_MEM,   B_FINAL, 1'b1, 1'b0, IDX_INC,  PASS_HOLD,
				C_NOT_LAST, L_FINAL_LOOP, 1'b0);
			6'd36: w = uw(OP_NOP,  A_MEM,   B_EDGE,  1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b1);
			default: w = uw(OP_NOP, A_MEM, B_EDGE, 1'b0, 1'b0, IDX_HOLD, PASS_HOLD,
				C_NEVER, L_NONE, 1'b1);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/recursive_gaussian_smoother.sv
// Top level of the recursive Gaussian smoother: handshakes, registers, result stage.
//
//  channel  signals                                  direction
//  in       in_valid/in_ready, func, position,       in
//           sample_in
//  out      out_valid/out_ready, sample_out,         out
//           out_position, run_done
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data in
//
// A load writes the store; a read result goes through the store read register into the
// output register. A run keeps the sequencer busy for P passes over L entries (at zero
// length it jumps to its end) and registers its result from the run-done state: each entry
// update is six control steps through the shared store ports and the two-step split
// multiplier. Reset clears control and loads the config defaults; the store is not
// cleared. A stalled output holds its result; input is taken again once it is registered.
`default_nettype none
module recursive_gaussian_smoother (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [rgs_pkg::FUNC_W-1:0]      func,
	input  wire logic [rgs_pkg::ADDR_W-1:0]      position,
	input  wire logic [rgs_pkg::SAMPLE_W-1:0]    sample_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [rgs_pkg::SAMPLE_W-1:0]         sample_out,
	output logic [rgs_pkg::ADDR_W-1:0]           out_position,
	output logic                                 run_done,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rgs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rgs_pkg::*;

	state_t               state_q;
	state_t               state_d;
	logic [LEN_W-1:0]     taps_q;
	logic [PASS_W-1:0]    pass_q;
	logic [COEF_W-1:0]    pole_q;
	logic [EDGE_W-1:0]    edge_q;
	logic [GAIN_W-1:0]    final_q;
	logic [ADDR_W-1:0]    pos_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  sample_out_q;
	logic [ADDR_W-1:0]    out_position_q;
	logic                 run_done_q;

	logic                 in_fire;
	logic                 out_free;
	logic                 host_we;
	logic                 host_re;
	logic                 seq_start;
	logic                 load_rd;
	logic                 load_run;
	dp_ctl_t              ctl;
	logic                 seq_busy;
	logic                 seq_done;
	logic [STORE_W-1:0]   rd_data;
	logic [STORE_W:0]     rd_round;
	logic [SAMPLE_W-1:0]  rd_sat;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func == FUNC_RUN) begin
						state_d = ST_RUN;
					end else if (func == FUNC_READ) begin
						state_d = ST_RD_DATA;
					end
				end
			end
			ST_RUN: begin
				if (seq_done) begin
					state_d = ST_RUN_DONE;
				end
			end
			ST_RD_DATA: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_RUN_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		host_we   = in_fire && (func == FUNC_LOAD);
		host_re   = in_fire && (func == FUNC_READ);
		seq_start = in_fire && (func == FUNC_RUN);
		load_rd   = (state_q == ST_RD_DATA) && out_free;
		load_run  = (state_q == ST_RUN_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q  <= LEN_W'(BUFFER_DEPTH);
			pass_q  <= PASS_W'(10);
			pole_q  <= '0;
			edge_q  <= EDGE_W'(1) << FRAC_W;
			final_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TAPS:  taps_q  <= cfg_data[LEN_W-1:0];
				CFG_PASS:  pass_q  <= cfg_data[PASS_W-1:0];
				CFG_POLE:  pole_q  <= cfg_data[COEF_W-1:0];
				CFG_EDGE:  edge_q  <= cfg_data[EDGE_W-1:0];
				CFG_FINAL: final_q <= cfg_data[GAIN_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (host_re) begin
			pos_q <= position;
		end
	end

	rgs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.taps   (taps_q),
		.passes (pass_q),
		.ctl    (ctl),
		.busy   (seq_busy),
		.done   (seq_done)
	);

	rgs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.host_we    (host_we),
		.host_re    (host_re),
		.host_addr  (position),
		.host_wdata (STORE_W'({sample_in, FRAC_W'(0)})),
		.pole       (pole_q),
		.edge_gain  (edge_q),
		.final_gain (final_q),
		.rd_data    (rd_data)
	);

	// round the stored Q40.16 entry to an integer, saturate to the sample width
	assign rd_round = {1'b0, rd_data} + (STORE_W+1)'(1 << (FRAC_W - 1));
	assign rd_sat   = (|rd_round[STORE_W:FRAC_W+SAMPLE_W]) ? '1
		: rd_round[FRAC_W+SAMPLE_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_rd || load_run) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rd) begin
			sample_out_q   <= rd_sat;
			out_position_q <= pos_q;
			run_done_q     <= 1'b0;
		end else if (load_run) begin
			sample_out_q   <= '0;
			out_position_q <= '0;
			run_done_q     <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_out_q;
	assign out_position = out_position_q;
	assign run_done     = run_done_q;

	// the host never touches the store while the program runs
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		seq_busy |-> !in_fire)
		else $error("input transaction accepted while the sequencer runs");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		seq_done |-> (state_q == ST_RUN))
		else $error("sequencer finished outside a run");

	a_run_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && run_done) |-> (sample_out == '0 && out_position == '0))
		else $error("run result carries a nonzero payload");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seq_start |=> seq_busy && (state_q == ST_RUN))
		else $error("run transaction did not start the sequencer");

endmodule
`default_nettype wire

// File: rtl/core/rgs_seq.sv
// Microcode sequencer: step counter, control store, entry index and pass counter.
`default_nettype none
module rgs_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rgs_pkg::LEN_W-1:0]   taps,
	input  wire logic [rgs_pkg::PASS_W-1:0]  passes,
	output rgs_pkg::dp_ctl_t                 ctl,
	output logic                             busy,
	output logic                             done
);
	import rgs_pkg::*;

	logic                running_q;
	logic [UPC_W-1:0]    upc_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [PASS_W-1:0]   pass_q;
	ucode_t              word;
	logic [LEN_W-1:0]    len;
	logic [ADDR_W-1:0]   last;
	logic [PASS_W-1:0]   eff_passes;
	logic                cond_hit;

	assign word       = ucode_word(upc_q);
	assign len        = (taps > LEN_W'(BUFFER_DEPTH)) ? LEN_W'(BUFFER_DEPTH) : taps;
	assign last       = ADDR_W'(len - LEN_W'(1));
	assign eff_passes = (passes > PASS_W'(MAX_PASSES)) ? PASS_W'(MAX_PASSES) : passes;

	always_comb begin
		case (word.cond)
			C_NEVER:     cond_hit = 1'b0;
			C_LEN_ZERO:  cond_hit = (taps == '0);
			C_NO_PASS:   cond_hit = (eff_passes == '0);
			C_SINGLE:    cond_hit = (last == '0);
			C_NOT_LAST:  cond_hit = (idx_q != last);
			C_NOT_FIRST: cond_hit = (idx_q != '0);
			C_PASS_MORE: cond_hit = ((pass_q + PASS_W'(1)) != eff_passes);
			default:     cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			upc_q     <= '0;
			idx_q     <= '0;
			pass_q    <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			upc_q     <= '0;
		end else if (running_q) begin
			if (word.done) begin
				running_q <= 1'b0;
			end
			upc_q <= cond_hit ? word.target : upc_q + UPC_W'(1);
			case (word.idx_op)
				IDX_HOLD: idx_q <= idx_q;
				IDX_ZERO: idx_q <= '0;
				IDX_LAST: idx_q <= last;
				IDX_INC:  idx_q <= idx_q + ADDR_W'(1);
				IDX_DEC:  idx_q <= idx_q - ADDR_W'(1);
				default:  idx_q <= idx_q;
			endcase
			case (word.pass_op)
				PASS_HOLD:  pass_q <= pass_q;
				PASS_CLEAR: pass_q <= '0;
				PASS_INC:   pass_q <= pass_q + PASS_W'(1);
				default:    pass_q <= pass_q;
			endcase
		end
	end

	always_comb begin
		ctl.op      = running_q ? word.op : OP_NOP;
		ctl.a_sel   = word.a_sel;
		ctl.b_sel   = word.b_sel;
		ctl.sh32    = word.sh32;
		ctl.add_mem = word.add_mem;
		ctl.addr    = idx_q;
	end

	assign busy = running_q;
	assign done = running_q && word.done;

endmodule
`default_nettype wire

// File: rtl/core/rgs_datapath.sv
// Sample store, shared split multiplier, rounding and saturating accumulate.
`default_nettype none
module rgs_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rgs_pkg::dp_ctl_t             ctl,
	input  wire logic                         host_we,
	input  wire logic                         host_re,
	input  wire logic [rgs_pkg::ADDR_W-1:0]   host_addr,
	input  wire logic [rgs_pkg::STORE_W-1:0]  host_wdata,
	input  wire logic [rgs_pkg::COEF_W-1:0]   pole,
	input  wire logic [rgs_pkg::EDGE_W-1:0]   edge_gain,
	input  wire logic [rgs_pkg::GAIN_W-1:0]   final_gain,
	output logic [rgs_pkg::STORE_W-1:0]       rd_data
);
	import rgs_pkg::*;

	logic [STORE_W-1:0]  mem [BUFFER_DEPTH];
	logic [STORE_W-1:0]  rd_q;
	logic [STORE_W-1:0]  carry_q;
	logic [PART_W-1:0]   plo_q;
	logic [PART_W-1:0]   phi_q;
	logic [PROD_W-1:0]   prod_q;
	logic [STORE_W-1:0]  rnd_q;

	logic [STORE_W-1:0]  a_op;
	logic [GAIN_W-1:0]   b_op;
	logic [PROD_W:0]     rnd_sum;
	logic [PROD_W:0]     shifted;
	logic [STORE_W-1:0]  rnd_val;
	logic [STORE_W:0]    wb_sum;
	logic [STORE_W-1:0]  wb_val;
	logic                mem_we;
	logic [ADDR_W-1:0]   waddr;
	logic [STORE_W-1:0]  wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   raddr;

	assign a_op = (ctl.a_sel == A_MEM) ? rd_q : carry_q;

	always_comb begin
		case (ctl.b_sel)
			B_EDGE:  b_op = GAIN_W'(edge_gain);
			B_NU:    b_op = GAIN_W'(pole);
			B_FINAL: b_op = final_gain;
			default: b_op = '0;
		endcase
	end

	// round half up, then drop the fraction bits of the coefficient
	assign rnd_sum = {1'b0, prod_q} + (ctl.sh32 ? ((PROD_W+1)'(1) << 31)
		: ((PROD_W+1)'(1) << (FRAC_W - 1)));
	assign shifted = ctl.sh32 ? (rnd_sum >> 32) : (rnd_sum >> FRAC_W);
	assign rnd_val = (|shifted[PROD_W:STORE_W]) ? STORE_MAX : shifted[STORE_W-1:0];

	assign wb_sum = {1'b0, rnd_q} + (ctl.add_mem ? {1'b0, rd_q} : (STORE_W+1)'(0));
	assign wb_val = wb_sum[STORE_W] ? STORE_MAX : wb_sum[STORE_W-1:0];

	assign mem_we = host_we || (ctl.op == OP_WB);
	assign waddr  = host_we ? host_addr : ctl.addr;
	assign wdata  = host_we ? host_wdata : wb_val;
	assign mem_re = host_re || (ctl.op == OP_READ);
	assign raddr  = host_re ? host_addr : ctl.addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_MLO:  plo_q  <= PART_W'(a_op[HALF_W-1:0]) * PART_W'(b_op);
			OP_MHI:  phi_q  <= PART_W'(a_op[STORE_W-1:HALF_W]) * PART_W'(b_op);
			OP_SUM:  prod_q <= {phi_q, HALF_W'(0)} + PROD_W'(plo_q);
			OP_RND:  rnd_q  <= rnd_val;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (ctl.op == OP_WB) begin
			carry_q <= wb_val;
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire
